/* sv/cgvs_pkg.sv */
// Package for the chunked growth vector store unit.
// Holds store geometry, field widths, reset values, status, action and config index codes and the step decision struct.
// No dependencies.
`default_nettype none
package cgvs_pkg;

  localparam int DEPTH     = 256;
  localparam int WORD_BITS = 32;
  localparam int ADDR_W    = $clog2(DEPTH);

  localparam int ACT_W  = 2;
  localparam int IDX_W  = 8;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 3;
  localparam int CNT_W  = 9;
  localparam int CFG_W  = 9;

  localparam logic [CNT_W:0] DEPTH_C = (CNT_W + 1)'(DEPTH);

  localparam logic [CFG_W-1:0] ORIG_CAP_RST = CFG_W'(16);
  localparam logic [CFG_W-1:0] BLOCK_RST    = CFG_W'(8);

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 3'd0,
    ST_NULL      = 3'd1,
    ST_BOUNDS    = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_ALLOC     = 3'd4,
    ST_UNDERFLOW = 3'd5
  } status_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_GET    = 2'd0,
    ACT_SET    = 2'd1,
    ACT_APPEND = 2'd2,
    ACT_REMOVE = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    CFG_ORIG_CAP = 1'b0,
    CFG_BLOCK    = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  cnt_nxt;
    logic [CNT_W-1:0]  cap_nxt;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ADDR_W-1:0] raddr;
    logic              rd_use;
  } decision_t;

endpackage
`default_nettype wire

/* sv/chunked_growth_vector_store_unit.sv */
// Top level of the chunked growth vector store unit: state, item store, result register.
// Depends on cgvs_pkg and cgvs_step.
`default_nettype none
// One item is taken in every cycle; busy is always low. The result of an item
// accepted at one edge shows on the out_ ports in the next cycle with
// out_valid high, so throughput is one item per cycle.
// Count and capacity update at the accept edge and the store read is registered
// there too, so back-to-back items see each other's effects. The receiver
// cannot stall and must take every result in the cycle it is shown.
// Write configuration only when no item is in flight.
module chunked_growth_vector_store_unit (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [cgvs_pkg::ACT_W-1:0]      in_action,
  input  wire logic [cgvs_pkg::IDX_W-1:0]      in_index,
  input  wire logic [cgvs_pkg::VAL_W-1:0]      in_value,
  output logic                                 out_valid,
  output logic [cgvs_pkg::STAT_W-1:0]          out_status,
  output logic [cgvs_pkg::VAL_W-1:0]           out_read_value,
  output logic [cgvs_pkg::CNT_W-1:0]           out_item_count,
  output logic [cgvs_pkg::CNT_W-1:0]           out_capacity_in_use,
  input  wire logic                            cfg_we,
  input  wire logic [0:0]                      cfg_index,
  input  wire logic [cgvs_pkg::CFG_W-1:0]      cfg_data
);

  logic [cgvs_pkg::WORD_BITS-1:0] mem [cgvs_pkg::DEPTH];
  logic [cgvs_pkg::WORD_BITS-1:0] mem_q_r;

  logic [cgvs_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [cgvs_pkg::CNT_W-1:0]  cap_r, cap_nxt;
  logic [cgvs_pkg::CFG_W-1:0]  orig_r, orig_nxt;
  logic [cgvs_pkg::CFG_W-1:0]  blk_r, blk_nxt;
  logic                        vld_r;
  logic                        rd_use_r;
  logic [cgvs_pkg::STAT_W-1:0] stat_r;
  logic [cgvs_pkg::CNT_W-1:0]  cnt_out_r;
  logic [cgvs_pkg::CNT_W-1:0]  cap_out_r;

  logic                        accept;
  logic [cgvs_pkg::CNT_W:0]    cfg_sat;
  logic [cgvs_pkg::CNT_W-1:0]  cfg_cap;
  cgvs_pkg::decision_t         dec;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  cgvs_step u_step (
    .action   (in_action),
    .index    (in_index),
    .value    (in_value),
    .count    (cnt_r),
    .cap      (cap_r),
    .orig_cap (orig_r),
    .blk      (blk_r),
    .dec      (dec)
  );

  // cfg capacity load: clamp to depth, raise to held count
  assign cfg_sat = ({1'b0, cfg_data} > cgvs_pkg::DEPTH_C) ? cgvs_pkg::DEPTH_C : {1'b0, cfg_data};
  assign cfg_cap = (cfg_sat[cgvs_pkg::CNT_W-1:0] < cnt_r) ? cnt_r
                                                         : cfg_sat[cgvs_pkg::CNT_W-1:0];

  always_comb begin
    cnt_nxt  = cnt_r;
    cap_nxt  = cap_r;
    orig_nxt = orig_r;
    blk_nxt  = blk_r;
    if (cfg_we) begin
      case (cgvs_pkg::cfg_idx_t'(cfg_index))
        cgvs_pkg::CFG_ORIG_CAP: begin
          orig_nxt = cfg_data;
          cap_nxt  = cfg_cap;
        end
        cgvs_pkg::CFG_BLOCK: blk_nxt = cfg_data;
        default: blk_nxt = blk_r;
      endcase
    end else if (accept) begin
      cnt_nxt = dec.cnt_nxt;
      cap_nxt = dec.cap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      cap_r  <= cgvs_pkg::ORIG_CAP_RST;
      orig_r <= cgvs_pkg::ORIG_CAP_RST;
      blk_r  <= cgvs_pkg::BLOCK_RST;
      vld_r  <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      cap_r  <= cap_nxt;
      orig_r <= orig_nxt;
      blk_r  <= blk_nxt;
      vld_r  <= accept;
    end
  end

  // item store
  always_ff @(posedge clk) begin
    if (accept && dec.we) mem[dec.waddr] <= in_value[cgvs_pkg::WORD_BITS-1:0];
    if (accept) mem_q_r <= mem[dec.raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_use_r  <= dec.rd_use;
      stat_r    <= dec.status;
      cnt_out_r <= dec.cnt_nxt;
      cap_out_r <= dec.cap_nxt;
    end
  end

  assign out_valid           = vld_r;
  assign out_status          = stat_r;
  assign out_read_value      = rd_use_r ? cgvs_pkg::VAL_W'(mem_q_r) : '0;
  assign out_item_count      = cnt_out_r;
  assign out_capacity_in_use = cap_out_r;

endmodule
`default_nettype wire

/* sv/cgvs_step.sv */
// Per-item decision logic: status, next count and capacity, store access.
// Depends on cgvs_pkg.
`default_nettype none
module cgvs_step (
  input  wire logic [cgvs_pkg::ACT_W-1:0] action,
  input  wire logic [cgvs_pkg::IDX_W-1:0] index,
  input  wire logic [cgvs_pkg::VAL_W-1:0] value,
  input  wire logic [cgvs_pkg::CNT_W-1:0] count,
  input  wire logic [cgvs_pkg::CNT_W-1:0] cap,
  input  wire logic [cgvs_pkg::CFG_W-1:0] orig_cap,
  input  wire logic [cgvs_pkg::CFG_W-1:0] blk,
  output cgvs_pkg::decision_t             dec
);

  logic                       word_zero;
  logic                       in_bounds;
  logic                       full;
  logic [cgvs_pkg::CNT_W:0]   grow_sum;
  logic                       grow_bad;
  logic [cgvs_pkg::CNT_W-1:0] cnt_dec;
  logic [cgvs_pkg::CNT_W:0]   gap;
  logic [cgvs_pkg::CNT_W:0]   two_blk;
  logic [cgvs_pkg::CNT_W:0]   cap_less;
  logic                       shrink;
  logic [cgvs_pkg::CNT_W-1:0] cap_grown;

  assign word_zero = (value[cgvs_pkg::WORD_BITS-1:0] == '0);
  assign in_bounds = ({1'b0, index} < count);
  assign full      = (count >= cap);
  assign grow_sum  = {1'b0, cap} + {1'b0, blk};
  assign grow_bad  = (grow_sum > cgvs_pkg::DEPTH_C);
  assign cap_grown = full ? grow_sum[cgvs_pkg::CNT_W-1:0] : cap;
  assign cnt_dec   = count - cgvs_pkg::CNT_W'(1);
  assign gap       = {1'b0, cap} - {1'b0, cnt_dec};
  assign two_blk   = {blk, 1'b0};
  assign cap_less  = {1'b0, cap} - {1'b0, blk};
  assign shrink    = (gap == two_blk) && ((blk > cap) || (cap_less >= {1'b0, orig_cap}));

  always_comb begin
    dec         = '0;
    dec.status  = cgvs_pkg::ST_OK;
    dec.cnt_nxt = count;
    dec.cap_nxt = cap;
    dec.waddr   = count[cgvs_pkg::ADDR_W-1:0];
    dec.raddr   = index[cgvs_pkg::ADDR_W-1:0];
    case (cgvs_pkg::action_t'(action))
      cgvs_pkg::ACT_GET: begin
        if (!in_bounds) dec.status = cgvs_pkg::ST_BOUNDS;
        else dec.rd_use = 1'b1;
      end
      cgvs_pkg::ACT_SET: begin
        dec.waddr = index[cgvs_pkg::ADDR_W-1:0];
        if (word_zero) dec.status = cgvs_pkg::ST_NULL;
        else if (!in_bounds) dec.status = cgvs_pkg::ST_BOUNDS;
        else dec.we = 1'b1;
      end
      cgvs_pkg::ACT_APPEND: begin
        if (word_zero) dec.status = cgvs_pkg::ST_NULL;
        else if (full && blk == '0) dec.status = cgvs_pkg::ST_OVERFLOW;
        else if (full && grow_bad) dec.status = cgvs_pkg::ST_ALLOC;
        else if ({1'b0, count} >= cgvs_pkg::DEPTH_C) begin
          dec.status  = cgvs_pkg::ST_ALLOC;
          dec.cap_nxt = cap_grown;
        end else begin
          dec.we      = 1'b1;
          dec.cnt_nxt = count + cgvs_pkg::CNT_W'(1);
          dec.cap_nxt = cap_grown;
        end
      end
      cgvs_pkg::ACT_REMOVE: begin
        dec.raddr = cnt_dec[cgvs_pkg::ADDR_W-1:0];
        if (count == '0) dec.status = cgvs_pkg::ST_UNDERFLOW;
        else begin
          dec.rd_use  = 1'b1;
          dec.cnt_nxt = cnt_dec;
          if (shrink) dec.cap_nxt = cap_less[cgvs_pkg::CNT_W-1:0];
        end
      end
      default: dec.status = cgvs_pkg::ST_OK;
    endcase
  end

endmodule
`default_nettype wire
